FILE: sv/qrs_pkg.sv
// Shared types and result-kind codes for the quadratic root solver.
package qrs_pkg;

    typedef logic [1:0] t_kind;

    localparam t_kind KIND_REAL = 2'd0;  // two real roots
    localparam t_kind KIND_CPLX = 2'd1;  // complex pair: real part and imaginary magnitude
    localparam t_kind KIND_LIN  = 2'd2;  // single root of b*x + c
    localparam t_kind KIND_DEG  = 2'd3;  // both coefficients of x zero

endpackage

FILE: sv/qrs_sqrt_cell.sv
// One step of the digit-by-digit square root: one root bit per cell.
module qrs_sqrt_cell #(
    parameter int ROOT_BITS = 33,
    parameter int TAG_BITS  = 1
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic [TAG_BITS-1:0]      i_tag,
    input  logic [2*ROOT_BITS-1:0]   i_rad,
    input  logic [ROOT_BITS+1:0]     i_rem,
    input  logic [ROOT_BITS-1:0]     i_root,
    output logic                     o_valid,
    output logic [TAG_BITS-1:0]      o_tag,
    output logic [2*ROOT_BITS-1:0]   o_rad,
    output logic [ROOT_BITS+1:0]     o_rem,
    output logic [ROOT_BITS-1:0]     o_root
);

    localparam int CW = ROOT_BITS + 4;

    logic                   r_valid;
    logic [TAG_BITS-1:0]    r_tag;
    logic [2*ROOT_BITS-1:0] r_rad;
    logic [ROOT_BITS+1:0]   r_rem;
    logic [ROOT_BITS-1:0]   r_root;

    logic [CW-1:0]          n_cur;
    logic [CW-1:0]          n_trial;
    logic [CW-1:0]          n_diff;
    logic                   n_take;
    logic [ROOT_BITS+1:0]   n_rem;
    logic [ROOT_BITS-1:0]   n_root;
    logic [2*ROOT_BITS-1:0] n_rad;

    always_comb begin
        // bring down the next two radicand bits and try root*4+1
        n_cur   = {i_rem, i_rad[2*ROOT_BITS-1 -: 2]};
        n_trial = CW'({i_root, 2'b01});
        n_take  = (n_cur >= n_trial);
        n_diff  = n_cur - n_trial;
        n_rem   = n_take ? n_diff[ROOT_BITS+1:0] : n_cur[ROOT_BITS+1:0];
        n_root  = {i_root[ROOT_BITS-2:0], n_take};
        n_rad   = {i_rad[2*ROOT_BITS-3:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag  <= i_tag;
        r_rad  <= n_rad;
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    assign o_valid = r_valid;
    assign o_tag   = r_tag;
    assign o_rad   = r_rad;
    assign o_rem   = r_rem;
    assign o_root  = r_root;

endmodule

FILE: sv/qrs_div_cell.sv
// One restoring division step for two lanes sharing a divisor: one quotient bit per cell.
module qrs_div_cell #(
    parameter int DEN_BITS = 33,
    parameter int QUO_BITS = 50,
    parameter int TAG_BITS = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic [TAG_BITS-1:0]            i_tag,
    input  logic [DEN_BITS-1:0]            i_den,
    input  logic [1:0][QUO_BITS-1:0]       i_num,
    input  logic [1:0][DEN_BITS-1:0]       i_rem,
    input  logic [1:0][QUO_BITS-1:0]       i_quo,
    output logic                           o_valid,
    output logic [TAG_BITS-1:0]            o_tag,
    output logic [DEN_BITS-1:0]            o_den,
    output logic [1:0][QUO_BITS-1:0]       o_num,
    output logic [1:0][DEN_BITS-1:0]       o_rem,
    output logic [1:0][QUO_BITS-1:0]       o_quo
);

    logic                       r_valid;
    logic [TAG_BITS-1:0]        r_tag;
    logic [DEN_BITS-1:0]        r_den;
    logic [1:0][QUO_BITS-1:0]   r_num;
    logic [1:0][DEN_BITS-1:0]   r_rem;
    logic [1:0][QUO_BITS-1:0]   r_quo;

    logic [1:0][DEN_BITS:0]     n_cur;
    logic [1:0][DEN_BITS:0]     n_diff;
    logic [1:0]                 n_take;
    logic [1:0][QUO_BITS-1:0]   n_num;
    logic [1:0][DEN_BITS-1:0]   n_rem;
    logic [1:0][QUO_BITS-1:0]   n_quo;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            // shift in the next dividend bit, subtract where it fits
            n_cur[l]  = {i_rem[l], i_num[l][QUO_BITS-1]};
            n_take[l] = (n_cur[l] >= {1'b0, i_den});
            n_diff[l] = n_cur[l] - {1'b0, i_den};
            n_rem[l]  = n_take[l] ? n_diff[l][DEN_BITS-1:0] : n_cur[l][DEN_BITS-1:0];
            n_quo[l]  = {i_quo[l][QUO_BITS-2:0], n_take[l]};
            n_num[l]  = {i_num[l][QUO_BITS-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag <= i_tag;
        r_den <= i_den;
        r_num <= n_num;
        r_rem <= n_rem;
        r_quo <= n_quo;
    end

    assign o_valid = r_valid;
    assign o_tag   = r_tag;
    assign o_den   = r_den;
    assign o_num   = r_num;
    assign o_rem   = r_rem;
    assign o_quo   = r_quo;

endmodule

FILE: sv/quadratic_root_solver.sv
// Top level of the quadratic root solver: front end, square-root chain, divider chain, packing.
//
// Solves a*x^2 + b*x + c = 0 for signed fixed-point coefficients (Q16.16 by default).
// One coefficient set is taken per transfer (start high while busy is low); busy is held
// low at all times, so a new set may be transferred in every clock cycle. Each set gives
// exactly one result, shown on the o_ ports for a single cycle with o_valid high, in
// transfer order. The receiver cannot stall the block, so take every result the cycle it
// appears. Each set passes through sign split, multiply and discriminant stages, one
// cell per root bit of the square-root chain (WORD_BITS+1 cells), a stage that forms
// numerators, one cell per quotient bit of the divider chain (WORD_BITS+2+FRACTION_BITS
// cells) and an output register. root_kind tells two real roots, a complex pair (real
// part, imaginary magnitude), a single linear root (second root zero) or the degenerate
// case a = b = 0 (all zero). Division truncates toward zero, the square root floors, and
// any root beyond the word range is clamped with o_saturated set.
module quadratic_root_solver #(
    parameter int WORD_BITS     = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic signed [WORD_BITS-1:0] i_coef_a,
    input  logic signed [WORD_BITS-1:0] i_coef_b,
    input  logic signed [WORD_BITS-1:0] i_coef_c,
    output logic                        o_valid,
    output logic signed [WORD_BITS-1:0] o_root_one,
    output logic signed [WORD_BITS-1:0] o_root_two,
    output logic [1:0]                  o_root_kind,
    output logic                        o_saturated
);

    localparam int W     = WORD_BITS;
    localparam int PW    = 2 * W;            // product width
    localparam int SW    = W + 1;            // square root width
    localparam int RADW  = 2 * SW;           // discriminant magnitude width
    localparam int NW    = W + 2;            // numerator magnitude width
    localparam int DENW  = W + 1;            // divisor width
    localparam int QW    = NW + FRACTION_BITS; // quotient width
    localparam int STAGW = 3 * W + 4;        // side data through the root chain
    localparam int DTAGW = 4;                // side data through the divider chain
    localparam logic [QW-1:0] HALF = QW'(1) << (W - 1);

    // sign-magnitude add; zero comes out positive
    function automatic logic [NW:0] sm_add(input logic s1, input logic [NW-1:0] m1,
                                           input logic s2, input logic [NW-1:0] m2);
        logic          s;
        logic [NW-1:0] m;
        if (s1 == s2) begin
            m = m1 + m2;
            s = s1;
        end else if (m1 >= m2) begin
            m = m1 - m2;
            s = s1;
        end else begin
            m = m2 - m1;
            s = s2;
        end
        if (m == '0) begin
            s = 1'b0;
        end
        return {s, m};
    endfunction

    // clamp a quotient magnitude to the word range and apply the sign
    function automatic logic [W:0] pack_root(input logic pre_neg, input logic [QW-1:0] q);
        logic          neg;
        logic [QW-1:0] lim;
        logic          over;
        logic [W-1:0]  m;
        neg  = pre_neg && (q != '0);
        lim  = neg ? HALF : HALF - QW'(1);
        over = (q > lim);
        m    = over ? lim[W-1:0] : q[W-1:0];
        return {over, neg ? (W'(0) - m) : m};
    endfunction

    wire accept = start && !busy;

    // ---------------- stage 1: split signs and magnitudes ----------------
    logic         r_s1_valid;
    logic         r_s1_sa, r_s1_sb, r_s1_sc;
    logic [W-1:0] r_s1_ma, r_s1_mb, r_s1_mc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        // a negative word always has a nonzero magnitude, so the sign is the top bit
        r_s1_sa <= i_coef_a[W-1];
        r_s1_sb <= i_coef_b[W-1];
        r_s1_sc <= i_coef_c[W-1];
        r_s1_ma <= i_coef_a[W-1] ? (W'(0) - W'(i_coef_a)) : W'(i_coef_a);
        r_s1_mb <= i_coef_b[W-1] ? (W'(0) - W'(i_coef_b)) : W'(i_coef_b);
        r_s1_mc <= i_coef_c[W-1] ? (W'(0) - W'(i_coef_c)) : W'(i_coef_c);
    end

    // ---------------- stage 2: products b*b and a*c ----------------
    logic          r_s2_valid;
    logic          r_s2_sa, r_s2_sb, r_s2_sc;
    logic [W-1:0]  r_s2_ma, r_s2_mb, r_s2_mc;
    logic [PW-1:0] r_s2_pbb, r_s2_pac;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_sa  <= r_s1_sa;
        r_s2_sb  <= r_s1_sb;
        r_s2_sc  <= r_s1_sc;
        r_s2_ma  <= r_s1_ma;
        r_s2_mb  <= r_s1_mb;
        r_s2_mc  <= r_s1_mc;
        r_s2_pbb <= r_s1_mb * r_s1_mb;
        r_s2_pac <= r_s1_ma * r_s1_mc;
    end

    // ---------------- stage 3: discriminant b*b - 4*a*c ----------------
    logic            r_s3_valid;
    logic [STAGW-1:0] r_s3_tag;
    logic [RADW-1:0] r_s3_dmag;

    logic [RADW-1:0] n_bb, n_ac4, n_dmag;
    logic            n_dneg;

    always_comb begin
        n_bb  = RADW'(r_s2_pbb);
        n_ac4 = {r_s2_pac, 2'b00};
        // the 4ac term is subtracted, so it is negative when a and c share a sign
        if (r_s2_sa != r_s2_sc) begin
            n_dmag = n_bb + n_ac4;
            n_dneg = 1'b0;
        end else if (n_bb >= n_ac4) begin
            n_dmag = n_bb - n_ac4;
            n_dneg = 1'b0;
        end else begin
            n_dmag = n_ac4 - n_bb;
            n_dneg = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3_tag  <= {n_dneg, r_s2_sa, r_s2_sb, r_s2_sc, r_s2_ma, r_s2_mb, r_s2_mc};
        r_s3_dmag <= n_dmag;
    end

    // ---------------- square-root chain: one root bit per cell ----------------
    logic [SW:0]                 sq_valid;
    logic [SW:0][STAGW-1:0]      sq_tag;
    logic [SW:0][RADW-1:0]       sq_rad;
    logic [SW:0][SW+1:0]         sq_rem;
    logic [SW:0][SW-1:0]         sq_root;

    assign sq_valid[0] = r_s3_valid;
    assign sq_tag[0]   = r_s3_tag;
    assign sq_rad[0]   = r_s3_dmag;
    assign sq_rem[0]   = '0;
    assign sq_root[0]  = '0;

    for (genvar k = 0; k < SW; k++) begin : g_sqrt
        qrs_sqrt_cell #(
            .ROOT_BITS (SW),
            .TAG_BITS  (STAGW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (sq_valid[k]),
            .i_tag   (sq_tag[k]),
            .i_rad   (sq_rad[k]),
            .i_rem   (sq_rem[k]),
            .i_root  (sq_root[k]),
            .o_valid (sq_valid[k+1]),
            .o_tag   (sq_tag[k+1]),
            .o_rad   (sq_rad[k+1]),
            .o_rem   (sq_rem[k+1]),
            .o_root  (sq_root[k+1])
        );
    end

    // ---------------- stage 4: pick case, form numerators and divisor ----------------
    logic         tg_dneg, tg_sa, tg_sb, tg_sc;
    logic [W-1:0] tg_ma, tg_mb, tg_mc;

    assign tg_mc   = sq_tag[SW][W-1:0];
    assign tg_mb   = sq_tag[SW][2*W-1:W];
    assign tg_ma   = sq_tag[SW][3*W-1:2*W];
    assign tg_sc   = sq_tag[SW][3*W];
    assign tg_sb   = sq_tag[SW][3*W+1];
    assign tg_sa   = sq_tag[SW][3*W+2];
    assign tg_dneg = sq_tag[SW][3*W+3];

    logic              r_s4_valid;
    logic [DTAGW-1:0]  r_s4_tag;
    logic [NW-1:0]     r_s4_num1, r_s4_num2;
    logic [DENW-1:0]   r_s4_den;

    qrs_pkg::t_kind  n_kind;
    logic [NW:0]     n_sum_p, n_sum_m;
    logic            n_negb;
    logic [NW-1:0]   n_num1, n_num2;
    logic [DENW-1:0] n_den;
    logic            n_p1, n_p2;

    always_comb begin
        n_negb  = !tg_sb && (tg_mb != '0);
        n_sum_p = sm_add(n_negb, NW'(tg_mb), 1'b0, NW'(sq_root[SW]));
        n_sum_m = sm_add(n_negb, NW'(tg_mb), 1'b1, NW'(sq_root[SW]));
        n_num1  = '0;
        n_num2  = '0;
        n_den   = '0;
        n_p1    = 1'b0;
        n_p2    = 1'b0;
        if (tg_ma == '0) begin
            if (tg_mb != '0) begin
                // linear: -c / b
                n_kind = qrs_pkg::KIND_LIN;
                n_num1 = NW'(tg_mc);
                n_den  = DENW'(tg_mb);
                n_p1   = (!tg_sc && (tg_mc != '0)) ^ tg_sb;
            end else begin
                n_kind = qrs_pkg::KIND_DEG;
            end
        end else if (!tg_dneg) begin
            n_kind = qrs_pkg::KIND_REAL;
            n_num1 = n_sum_p[NW-1:0];
            n_num2 = n_sum_m[NW-1:0];
            n_den  = {tg_ma, 1'b0};
            n_p1   = n_sum_p[NW] ^ tg_sa;
            n_p2   = n_sum_m[NW] ^ tg_sa;
        end else begin
            // complex: -b/(2a) and sqrt(-D)/(2|a|)
            n_kind = qrs_pkg::KIND_CPLX;
            n_num1 = NW'(tg_mb);
            n_num2 = NW'(sq_root[SW]);
            n_den  = {tg_ma, 1'b0};
            n_p1   = n_negb ^ tg_sa;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid <= 1'b0;
        end else begin
            r_s4_valid <= sq_valid[SW];
        end
    end

    always_ff @(posedge i_clk) begin
        r_s4_tag  <= {n_kind, n_p1, n_p2};
        r_s4_num1 <= n_num1;
        r_s4_num2 <= n_num2;
        r_s4_den  <= n_den;
    end

    // ---------------- divider chain: one quotient bit per cell, two lanes ----------------
    logic [QW:0]                   dv_valid;
    logic [QW:0][DTAGW-1:0]        dv_tag;
    logic [QW:0][DENW-1:0]         dv_den;
    logic [QW:0][1:0][QW-1:0]      dv_num;
    logic [QW:0][1:0][DENW-1:0]    dv_rem;
    logic [QW:0][1:0][QW-1:0]      dv_quo;

    assign dv_valid[0]  = r_s4_valid;
    assign dv_tag[0]    = r_s4_tag;
    assign dv_den[0]    = r_s4_den;
    assign dv_num[0][0] = QW'(r_s4_num1) << FRACTION_BITS;
    assign dv_num[0][1] = QW'(r_s4_num2) << FRACTION_BITS;
    assign dv_rem[0]    = '0;
    assign dv_quo[0]    = '0;

    for (genvar k = 0; k < QW; k++) begin : g_div
        qrs_div_cell #(
            .DEN_BITS (DENW),
            .QUO_BITS (QW),
            .TAG_BITS (DTAGW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (dv_valid[k]),
            .i_tag   (dv_tag[k]),
            .i_den   (dv_den[k]),
            .i_num   (dv_num[k]),
            .i_rem   (dv_rem[k]),
            .i_quo   (dv_quo[k]),
            .o_valid (dv_valid[k+1]),
            .o_tag   (dv_tag[k+1]),
            .o_den   (dv_den[k+1]),
            .o_num   (dv_num[k+1]),
            .o_rem   (dv_rem[k+1]),
            .o_quo   (dv_quo[k+1])
        );
    end

    // ---------------- output stage: clamp, sign and hold for one cycle ----------------
    qrs_pkg::t_kind n_out_kind;
    logic [W:0]     n_pk1, n_pk2;
    logic [W-1:0]   n_r1, n_r2;
    logic           n_sat;

    logic           r_valid;
    logic [W-1:0]   r_root_one, r_root_two;
    qrs_pkg::t_kind r_kind;
    logic           r_sat;

    always_comb begin
        n_out_kind = dv_tag[QW][3:2];
        n_pk1      = pack_root(dv_tag[QW][1], dv_quo[QW][0]);
        n_pk2      = pack_root(dv_tag[QW][0], dv_quo[QW][1]);
        case (n_out_kind)
            qrs_pkg::KIND_LIN: begin
                n_r1  = n_pk1[W-1:0];
                n_r2  = '0;
                n_sat = n_pk1[W];
            end
            qrs_pkg::KIND_DEG: begin
                n_r1  = '0;
                n_r2  = '0;
                n_sat = 1'b0;
            end
            default: begin
                n_r1  = n_pk1[W-1:0];
                n_r2  = n_pk2[W-1:0];
                n_sat = n_pk1[W] | n_pk2[W];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= dv_valid[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        r_root_one <= n_r1;
        r_root_two <= n_r2;
        r_kind     <= n_out_kind;
        r_sat      <= n_sat;
    end

    assign busy        = 1'b0;
    assign o_valid     = r_valid;
    assign o_root_one  = r_root_one;
    assign o_root_two  = r_root_two;
    assign o_root_kind = r_kind;
    assign o_saturated = r_sat;

endmodule

FILE: sv/qrs_checker.sv
// Port-level checks on the quadratic root solver, bound to the top level.
module qrs_checker #(
    parameter int WORD_BITS = 32
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 busy,
    input logic                 o_valid,
    input logic [WORD_BITS-1:0] o_root_one,
    input logic [WORD_BITS-1:0] o_root_two,
    input logic [1:0]           o_root_kind,
    input logic                 o_saturated
);

    // the block takes a transfer in every cycle
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy raised");

    // degenerate results carry nothing
    a_deg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_root_kind == qrs_pkg::KIND_DEG) |->
            (o_root_one == '0 && o_root_two == '0 && !o_saturated))
        else $error("degenerate result not zero");

    // a linear equation has no second root
    a_lin_second_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_root_kind == qrs_pkg::KIND_LIN) |-> (o_root_two == '0))
        else $error("linear result with nonzero second root");

    // the imaginary magnitude is never negative
    a_imag_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_root_kind == qrs_pkg::KIND_CPLX) |-> !o_root_two[WORD_BITS-1])
        else $error("negative imaginary magnitude");

endmodule

bind quadratic_root_solver qrs_checker #(
    .WORD_BITS (WORD_BITS)
) u_qrs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .busy        (busy),
    .o_valid     (o_valid),
    .o_root_one  (o_root_one),
    .o_root_two  (o_root_two),
    .o_root_kind (o_root_kind),
    .o_saturated (o_saturated)
);
